@@ rtl/dvd_pkg.sv @@
// ----------------------------------------------------------------------------
// dvd_pkg
// Constants and types for the delta varint decoder and summer.
// ----------------------------------------------------------------------------
package dvd_pkg;

  // longest code in bytes (1..9)
  localparam int unsigned MAX_CODE_BYTES = 7;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned GROUP_W = 7;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned PART_W  = GROUP_W * MAX_CODE_BYTES;
  localparam int unsigned CNT_W   = (MAX_CODE_BYTES > 1) ? $clog2(MAX_CODE_BYTES) : 1;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 2 * VALUE_W;
  localparam int unsigned OUT_TUSER_W = 2;

  // output request: tuser holds {bad_length, end_of_list}
  typedef struct packed {
    logic               bad_length;
    logic               end_of_list;
    logic [VALUE_W-1:0] running_sum;
    logic [VALUE_W-1:0] element_value;
  } dvd_result_t;

endpackage

@@ rtl/delta_varint_decode_sum.sv @@
// ----------------------------------------------------------------------------
// delta_varint_decode_sum
// Byte-serial LEB128 delta decoder with running element and running sum.
// ----------------------------------------------------------------------------
// One byte per request enters on the slave side; one byte is taken every cycle
// while the result side keeps up. A byte passes an input register, then a
// single update stage (data-group insert, a 64-bit add for the element and a
// three-operand 64-bit add for the sum) writes the output register. Bytes that
// only continue a code yield no result. A 0x00 byte at the start of a code
// gives the final sum with end_of_list (tuser[0]) and clears the state; a code
// whose last allowed byte still has bit 7 set gives bad_length (tuser[1]) with
// the unchanged element and sum, and the partial code is dropped.
// ----------------------------------------------------------------------------
module delta_varint_decode_sum (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [dvd_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,  // [7:0] data_byte
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [dvd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,  // [63:0] element_value,
                                                               // [127:64] running_sum
  output logic [dvd_pkg::OUT_TUSER_W-1:0]     m_axis_tuser_o   // [0] end_of_list,
                                                               // [1] bad_length
);
  import dvd_pkg::*;

  // input register
  logic [BYTE_W-1:0]  byte_q;
  logic               byte_vld_q;

  // decoder state
  logic [PART_W-1:0]  part_q,  part_d;
  logic [CNT_W-1:0]   cnt_q,   cnt_d;
  logic [VALUE_W-1:0] elem_q,  elem_d;
  logic [VALUE_W-1:0] sum_q,   sum_d;

  // output register
  dvd_result_t        res_q,   res_d;
  logic               out_vld_q;

  logic               lead_zero;
  logic               cont;
  logic               too_long;
  logic               has_res;
  logic               advance;
  logic [PART_W-1:0]  part_full;
  logic [VALUE_W-1:0] diff;

  assign lead_zero = (cnt_q == '0) && (byte_q == '0);
  assign cont      = byte_q[BYTE_W-1];
  assign too_long  = cont && (cnt_q == CNT_W'(MAX_CODE_BYTES - 1));
  assign has_res   = lead_zero || !cont || too_long;

  // stage fires when it holds a byte and the result slot is free (or not needed)
  assign advance         = byte_vld_q && (!has_res || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !byte_vld_q || advance;

  assign part_full = part_q
                   | (PART_W'(byte_q[GROUP_W-1:0]) << (GROUP_W * 32'(cnt_q)));
  assign diff      = VALUE_W'(part_full);

  always_comb begin
    part_d = part_q;
    cnt_d  = cnt_q;
    elem_d = elem_q;
    sum_d  = sum_q;
    res_d  = '{bad_length: 1'b0, end_of_list: 1'b0,
               running_sum: sum_q, element_value: elem_q};
    if (lead_zero) begin
      res_d.end_of_list = 1'b1;
      part_d = '0;
      cnt_d  = '0;
      elem_d = '0;
      sum_d  = '0;
    end else if (too_long) begin
      res_d.bad_length = 1'b1;
      part_d = '0;
      cnt_d  = '0;
    end else if (cont) begin
      part_d = part_full;
      cnt_d  = cnt_q + CNT_W'(1);
    end else begin
      // sum adds the old element plus the difference, in parallel with the element add
      elem_d = elem_q + diff;
      sum_d  = sum_q + elem_q + diff;
      part_d = '0;
      cnt_d  = '0;
      res_d.element_value = elem_d;
      res_d.running_sum   = sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      byte_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      byte_q <= s_axis_tdata_i[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      cnt_q  <= '0;
      elem_q <= '0;
      sum_q  <= '0;
    end else if (advance) begin
      part_q <= part_d;
      cnt_q  <= cnt_d;
      elem_q <= elem_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && has_res) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_res) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {res_q.running_sum, res_q.element_value};
  assign m_axis_tuser_o  = {res_q.bad_length, res_q.end_of_list};

  // byte count never reaches the code limit
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) < MAX_CODE_BYTES)
    else $error("byte count out of range");

  // a result never carries both flags
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(res_q.end_of_list && res_q.bad_length))
    else $error("end_of_list and bad_length both set");

  // end of list clears the running state
  a_eol_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && lead_zero) |=> (elem_q == '0 && sum_q == '0 && cnt_q == '0))
    else $error("state not cleared after end of list");

  // a pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |-> !(advance && has_res))
    else $error("pending result overwritten");

endmodule
